// ===== rtl/ddmix_pkg.sv =====
// ============================================================================
// ddmix_pkg: shared types and constants of the differential drive mixer
// Holds the datapath command and status bundles, register indexes, reset
// values and the functions that build the factor table of the exp2 sequence.
// ============================================================================
`default_nettype none

package ddmix_pkg;

    // Interface widths.
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int DacBitsDefault = 15;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEADZONE    = 3'd0,
        CFG_FWD_EXP     = 3'd1,
        CFG_TURN_EXP    = 3'd2,
        CFG_TURN_RED    = 3'd3,
        CFG_ALPHA       = 3'd4,
        CFG_MIN_CODE    = 3'd5,
        CFG_MAX_CODE    = 3'd6,
        CFG_POLARITY    = 3'd7
    } t_cfg_idx;

    // Register reset values.
    localparam logic [14:0] RstDeadzone = 15'd1638;
    localparam logic [9:0]  RstFwdExp   = 10'd333;
    localparam logic [9:0]  RstTurnExp  = 10'd307;
    localparam logic [15:0] RstTurnRed  = 16'd22938;
    localparam logic [15:0] RstAlpha    = 16'd16384;
    localparam logic [14:0] RstMinCode  = 15'd0;
    localparam logic [14:0] RstMaxCode  = 15'd32767;
    localparam logic [1:0]  RstPolarity = 2'd0;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SETUP,
        OP_SQUARE,
        OP_LOGMUL,
        OP_EXPMUL,
        OP_AXDONE,
        OP_TURN1,
        OP_TURN2,
        OP_MIX,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_DIVDONE,
        OP_SMOOTH,
        OP_CODE,
        OP_OUTPUT
    } t_op;

    // Command bundle: sel picks the axis (0 forward, 1 turn) or the side
    // (0 left, 1 right); idx is the step index of iterated operations.
    typedef struct packed {
        logic       load;
        t_op        op;
        logic       sel;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic need_norm;
    } t_status;

    // Integer square root, used only at elaboration to build the table.
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Q30 factor 2^-(2^(b-16)) for fraction bit b, by repeated square roots.
    function automatic logic [31:0] exp_factor(int b);
        logic [63:0] t;
        t = 64'd1 << 29;
        for (int j = 0; j < 16; j++) begin
            if (j < 16 - b) begin
                t = isqrt64(t << 30);
            end
        end
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ddmix_ctrl.sv =====
// ============================================================================
// ddmix_ctrl: sequencer of the differential drive mixer
// Steps the datapath through the two power curves, the turn factor, the
// optional renormalizing division, smoothing and code mapping, and owns
// both handshakes.
// ============================================================================
`default_nettype none

module ddmix_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ddmix_pkg::t_cmd         o_cmd,
    input  wire ddmix_pkg::t_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_SQUARE,
        S_LOGMUL,
        S_EXPMUL,
        S_AXDONE,
        S_TURN1,
        S_TURN2,
        S_MIX,
        S_RENORM,
        S_DIVINIT,
        S_DIVSTEP,
        S_DIVDONE,
        S_SMOOTH,
        S_CODE,
        S_FINISH
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic       r_axis;
    logic       r_side;
    logic       r_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Command decode from the current state.
    always_comb begin
        o_cmd.load = w_accept;
        o_cmd.idx  = r_cnt;
        o_cmd.sel  = r_side;
        o_cmd.op   = ddmix_pkg::OP_NONE;
        case (r_state)
            S_SETUP: begin
                o_cmd.op  = ddmix_pkg::OP_SETUP;
                o_cmd.sel = r_axis;
            end
            S_SQUARE: begin
                o_cmd.op  = ddmix_pkg::OP_SQUARE;
                o_cmd.sel = r_axis;
            end
            S_LOGMUL: begin
                o_cmd.op  = ddmix_pkg::OP_LOGMUL;
                o_cmd.sel = r_axis;
            end
            S_EXPMUL: begin
                o_cmd.op  = ddmix_pkg::OP_EXPMUL;
                o_cmd.sel = r_axis;
            end
            S_AXDONE: begin
                o_cmd.op  = ddmix_pkg::OP_AXDONE;
                o_cmd.sel = r_axis;
            end
            S_TURN1:   o_cmd.op = ddmix_pkg::OP_TURN1;
            S_TURN2:   o_cmd.op = ddmix_pkg::OP_TURN2;
            S_MIX:     o_cmd.op = ddmix_pkg::OP_MIX;
            S_DIVINIT: o_cmd.op = ddmix_pkg::OP_DIVINIT;
            S_DIVSTEP: o_cmd.op = ddmix_pkg::OP_DIVSTEP;
            S_DIVDONE: o_cmd.op = ddmix_pkg::OP_DIVDONE;
            S_SMOOTH:  o_cmd.op = ddmix_pkg::OP_SMOOTH;
            S_CODE:    o_cmd.op = ddmix_pkg::OP_CODE;
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.op = ddmix_pkg::OP_OUTPUT;
                end
            end
            default:   o_cmd.op = ddmix_pkg::OP_NONE;
        endcase
    end

    // State, step counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The finish step reloads valid itself when the result is taken.
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SETUP;
                        r_axis  <= 1'b0;
                        r_side  <= 1'b0;
                    end
                end
                S_SETUP: begin
                    r_cnt   <= '0;
                    r_state <= S_SQUARE;
                end
                S_SQUARE: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_LOGMUL;
                    end
                end
                S_LOGMUL: begin
                    r_cnt   <= 4'd15;
                    r_state <= S_EXPMUL;
                end
                S_EXPMUL: begin
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_AXDONE;
                    end
                end
                S_AXDONE: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_TURN1;
                    end
                end
                S_TURN1: r_state <= S_TURN2;
                S_TURN2: r_state <= S_MIX;
                S_MIX:   r_state <= S_RENORM;
                S_RENORM: begin
                    r_side  <= 1'b0;
                    r_state <= i_status.need_norm ? S_DIVINIT : S_SMOOTH;
                end
                S_DIVINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIVSTEP;
                end
                S_DIVSTEP: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_DIVDONE;
                    end
                end
                S_DIVDONE: begin
                    r_side  <= !r_side;
                    r_state <= r_side ? S_SMOOTH : S_DIVINIT;
                end
                S_SMOOTH: begin
                    r_side  <= !r_side;
                    r_state <= r_side ? S_CODE : S_SMOOTH;
                end
                S_CODE: begin
                    r_side  <= !r_side;
                    r_state <= r_side ? S_FINISH : S_CODE;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ddmix_pkg::OP_OUTPUT) |-> w_out_free)
        else $error("result loaded over a pending result");

    // An accepted request starts with the forward axis.
    a_start_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SETUP && !r_axis))
        else $error("request did not start on the forward axis");

    // Output valid only rises at the end of a sequence.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("output valid rose outside the finish step");
`endif

endmodule

`default_nettype wire

// ===== rtl/ddmix_dp.sv =====
// ============================================================================
// ddmix_dp: datapath of the differential drive mixer
// Configuration registers, one shared 32x32 multiplier, a shift-subtract
// divider, the smoothing state and the result registers.
// ============================================================================
`default_nettype none

module ddmix_dp #(
    parameter int DAC_BITS = ddmix_pkg::DacBitsDefault
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ddmix_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [ddmix_pkg::CfgDataW-1:0] i_cfg_data,
    input  wire logic signed [15:0]            i_stick_x,
    input  wire logic signed [15:0]            i_stick_y,
    input  wire logic signed [15:0]            i_speed_left,
    input  wire logic signed [15:0]            i_speed_right,
    input  wire ddmix_pkg::t_cmd               i_cmd,
    output ddmix_pkg::t_status                 o_status,
    output logic [14:0]                        o_left_code,
    output logic                               o_left_reverse,
    output logic [14:0]                        o_right_code,
    output logic                               o_right_reverse,
    output logic signed [16:0]                 o_left_command,
    output logic signed [16:0]                 o_right_command
);

    localparam logic signed [17:0] CodeCeil = 18'((1 << DAC_BITS) - 1);

    // Configuration registers.
    logic [14:0] r_dz;
    logic [9:0]  r_fexp;
    logic [9:0]  r_texp;
    logic [15:0] r_tred;
    logic [15:0] r_alpha;
    logic [14:0] r_minc;
    logic [14:0] r_maxc;
    logic [1:0]  r_pol;

    // Captured request.
    logic signed [15:0] r_sx, r_sy, r_sl, r_sr;

    // Power curve state.
    logic        r_neg, r_zero;
    logic [3:0]  r_k;
    logic [30:0] r_x;
    logic [15:0] r_frac;
    logic [5:0]  r_ip;
    logic [15:0] r_f;
    logic [30:0] r_r;
    logic signed [16:0] r_ysh, r_xsh;

    // Mixing, division, smoothing and code state.
    logic [31:0]        r_p;
    logic signed [16:0] r_xe;
    logic signed [17:0] r_lr, r_rr;
    logic [16:0]        r_mx;
    logic [17:0]        r_rem;
    logic [15:0]        r_q;
    logic signed [16:0] r_prevl, r_prevr;
    logic [14:0]        r_codel, r_coder;
    logic               r_revl, r_revr;

    // Exp2 factor table.
    logic [31:0] w_tab [16];
    for (genvar g = 0; g < 16; g++) begin : g_tab
        assign w_tab[g] = ddmix_pkg::exp_factor(g);
    end

    // Combinational helpers.
    logic signed [15:0] w_v;
    logic [15:0]        w_m;
    logic [3:0]         w_k;
    logic [4:0]         w_nsh;
    logic               w_zero;
    logic [9:0]         w_e;
    logic [19:0]        w_n;
    logic [31:0]        w_ma, w_mb;
    logic [63:0]        w_prod;
    logic [31:0]        w_sq;
    logic [6:0]         w_shift;
    logic [15:0]        w_mag;
    logic signed [16:0] w_shaped;
    logic [15:0]        w_asl, w_asr;
    logic [16:0]        w_ssum;
    logic [15:0]        w_avg;
    logic [16:0]        w_pp;
    logic [15:0]        w_fac;
    logic [15:0]        w_xm;
    logic [16:0]        w_xemag;
    logic signed [17:0] w_lr, w_rr;
    logic [16:0]        w_la, w_ra;
    logic               w_cmp;
    logic [16:0]        w_diff;
    logic signed [17:0] w_divres;
    logic [15:0]        w_alpha;
    logic signed [17:0] w_raw;
    logic signed [16:0] w_prev;
    logic signed [18:0] w_d;
    logic [17:0]        w_ad;
    logic [33:0]        w_rsum;
    logic signed [19:0] w_step;
    logic signed [19:0] w_c;
    logic signed [16:0] w_cmd_sat;
    logic signed [16:0] w_cur;
    logic [15:0]        w_cmag;
    logic signed [15:0] w_span;
    logic [14:0]        w_aspan;
    logic signed [17:0] w_part;
    logic signed [17:0] w_code;

    always_comb begin
        // Axis setup: magnitude, top bit and normalized mantissa.
        w_v = i_cmd.sel ? r_sx : r_sy;
        w_m = w_v[15] ? 16'(-w_v) : 16'(w_v);
        w_k = '0;
        for (int i = 0; i < 16; i++) begin
            if (w_m[i]) begin
                w_k = 4'(i);
            end
        end
        w_nsh  = 5'd30 - {1'b0, w_k};
        w_zero = (w_m < {1'b0, r_dz}) || (w_m == 16'd0);
        w_e    = i_cmd.sel ? r_texp : r_fexp;
        w_n    = {4'd15 - r_k, 16'd0} - {4'd0, r_frac};

        // Curve result.
        w_shift  = 7'd15 + {1'b0, r_ip};
        w_mag    = (w_shift > 7'd40) ? 16'd0 : 16'(r_r >> w_shift);
        w_shaped = r_zero ? 17'sd0 :
                   (r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag}));

        // Turn factor.
        w_asl  = r_sl[15] ? 16'(-r_sl) : 16'(r_sl);
        w_asr  = r_sr[15] ? 16'(-r_sr) : 16'(r_sr);
        w_ssum = {1'b0, w_asl} + {1'b0, w_asr};
        w_avg  = w_ssum[16:1];
        w_pp   = r_p[31:15];
        w_fac  = (w_pp > 17'd32768) ? 16'd0 : 16'(17'd32768 - w_pp);
        w_xm   = r_xsh[16] ? 16'(-r_xsh) : 16'(r_xsh);

        // Mixing.
        w_lr = 18'(r_ysh) + 18'(r_xe);
        w_rr = 18'(r_ysh) - 18'(r_xe);
        w_la = w_lr[17] ? 17'(-w_lr) : 17'(w_lr);
        w_ra = w_rr[17] ? 17'(-w_rr) : 17'(w_rr);

        // Divider step.
        w_cmp    = (r_rem >= {1'b0, r_mx});
        w_diff   = w_cmp ? 17'(r_rem - {1'b0, r_mx}) : r_rem[16:0];
        w_divres = (i_cmd.sel ? r_rr[17] : r_lr[17]) ?
                   -$signed({2'b00, r_q}) : $signed({2'b00, r_q});

        // Smoothing.
        if (r_alpha < 16'd328) begin
            w_alpha = 16'd328;
        end else if (r_alpha > 16'd32768) begin
            w_alpha = 16'd32768;
        end else begin
            w_alpha = r_alpha;
        end
        w_raw  = i_cmd.sel ? r_rr : r_lr;
        w_prev = i_cmd.sel ? r_prevr : r_prevl;
        w_d    = 19'(w_raw) - 19'(w_prev);
        w_ad   = w_d[18] ? 18'(-w_d) : 18'(w_d);

        // Code mapping.
        w_cur   = i_cmd.sel ? r_prevr : r_prevl;
        w_cmag  = w_cur[16] ? 16'(-w_cur) : 16'(w_cur);
        w_span  = $signed({1'b0, r_maxc}) - $signed({1'b0, r_minc});
        w_aspan = w_span[15] ? 15'(-w_span) : 15'(w_span);

        // Shared multiplier operand selection.
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            ddmix_pkg::OP_SQUARE: begin
                w_ma = {1'b0, r_x};
                w_mb = {1'b0, r_x};
            end
            ddmix_pkg::OP_LOGMUL: begin
                w_ma = {12'd0, w_n};
                w_mb = {22'd0, w_e};
            end
            ddmix_pkg::OP_EXPMUL: begin
                w_ma = {1'b0, r_r};
                w_mb = w_tab[i_cmd.idx];
            end
            ddmix_pkg::OP_TURN1: begin
                w_ma = {16'd0, r_tred};
                w_mb = {16'd0, w_avg};
            end
            ddmix_pkg::OP_TURN2: begin
                w_ma = {16'd0, w_xm};
                w_mb = {16'd0, w_fac};
            end
            ddmix_pkg::OP_SMOOTH: begin
                w_ma = {16'd0, w_alpha};
                w_mb = {14'd0, w_ad};
            end
            ddmix_pkg::OP_CODE: begin
                w_ma = {16'd0, w_cmag};
                w_mb = {17'd0, w_aspan};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = {32'd0, w_ma} * {32'd0, w_mb};

        // Product post-processing.
        w_sq    = w_prod[61:30];
        w_xemag = w_prod[31:15];
        w_rsum  = w_prod[33:0] + 34'd16384;
        w_step  = $signed({1'b0, w_rsum[33:15]});
        w_c     = w_d[18] ? (20'(w_prev) - w_step) : (20'(w_prev) + w_step);
        if (w_c > 20'sd32768) begin
            w_cmd_sat = 17'sd32768;
        end else if (w_c < -20'sd32768) begin
            w_cmd_sat = -17'sd32768;
        end else begin
            w_cmd_sat = 17'(w_c);
        end
        w_part = w_span[15] ? -$signed({2'b00, w_prod[30:15]})
                            : $signed({2'b00, w_prod[30:15]});
        w_code = $signed({3'b000, r_minc}) + w_part;
        if (w_code > $signed({3'b000, r_maxc})) begin
            w_code = $signed({3'b000, r_maxc});
        end
        if (w_code > CodeCeil) begin
            w_code = CodeCeil;
        end
        if (w_code < 18'sd0) begin
            w_code = 18'sd0;
        end
    end

    assign o_status.need_norm = (r_mx > 17'd32768);

    // Configuration registers and smoothing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz    <= ddmix_pkg::RstDeadzone;
            r_fexp  <= ddmix_pkg::RstFwdExp;
            r_texp  <= ddmix_pkg::RstTurnExp;
            r_tred  <= ddmix_pkg::RstTurnRed;
            r_alpha <= ddmix_pkg::RstAlpha;
            r_minc  <= ddmix_pkg::RstMinCode;
            r_maxc  <= ddmix_pkg::RstMaxCode;
            r_pol   <= ddmix_pkg::RstPolarity;
            r_prevl <= '0;
            r_prevr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (ddmix_pkg::t_cfg_idx'(i_cfg_idx))
                    ddmix_pkg::CFG_DEADZONE: r_dz    <= i_cfg_data[14:0];
                    ddmix_pkg::CFG_FWD_EXP:  r_fexp  <= i_cfg_data[9:0];
                    ddmix_pkg::CFG_TURN_EXP: r_texp  <= i_cfg_data[9:0];
                    ddmix_pkg::CFG_TURN_RED: r_tred  <= i_cfg_data;
                    ddmix_pkg::CFG_ALPHA:    r_alpha <= i_cfg_data;
                    ddmix_pkg::CFG_MIN_CODE: r_minc  <= i_cfg_data[14:0];
                    ddmix_pkg::CFG_MAX_CODE: r_maxc  <= i_cfg_data[14:0];
                    ddmix_pkg::CFG_POLARITY: r_pol   <= i_cfg_data[1:0];
                    default: r_pol <= r_pol;
                endcase
            end
            if (i_cmd.op == ddmix_pkg::OP_SMOOTH) begin
                if (i_cmd.sel) begin
                    r_prevr <= w_cmd_sat;
                end else begin
                    r_prevl <= w_cmd_sat;
                end
            end
        end
    end

    // Working registers, stepped by the controller.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= i_stick_x;
            r_sy <= i_stick_y;
            r_sl <= i_speed_left;
            r_sr <= i_speed_right;
        end
        case (i_cmd.op)
            ddmix_pkg::OP_SETUP: begin
                r_neg  <= w_v[15];
                r_zero <= w_zero;
                r_k    <= w_k;
                r_x    <= 31'(w_m) << w_nsh;
                r_frac <= '0;
            end
            ddmix_pkg::OP_SQUARE: begin
                r_x    <= w_sq[31] ? w_sq[31:1] : w_sq[30:0];
                r_frac <= {r_frac[14:0], w_sq[31]};
            end
            ddmix_pkg::OP_LOGMUL: begin
                r_ip <= w_prod[29:24];
                r_f  <= w_prod[23:8];
                r_r  <= 31'h4000_0000;
            end
            ddmix_pkg::OP_EXPMUL: begin
                if (r_f[i_cmd.idx]) begin
                    r_r <= w_prod[60:30];
                end
            end
            ddmix_pkg::OP_AXDONE: begin
                if (i_cmd.sel) begin
                    r_xsh <= w_shaped;
                end else begin
                    r_ysh <= w_shaped;
                end
            end
            ddmix_pkg::OP_TURN1: r_p <= w_prod[31:0];
            ddmix_pkg::OP_TURN2: begin
                r_xe <= r_xsh[16] ? -$signed(w_xemag) : $signed(w_xemag);
            end
            ddmix_pkg::OP_MIX: begin
                r_lr <= w_lr;
                r_rr <= w_rr;
                r_mx <= (w_la > w_ra) ? w_la : w_ra;
            end
            ddmix_pkg::OP_DIVINIT: begin
                r_rem <= {1'b0, (i_cmd.sel ? w_ra : w_la)};
                r_q   <= '0;
            end
            ddmix_pkg::OP_DIVSTEP: begin
                r_rem <= {w_diff, 1'b0};
                r_q   <= {r_q[14:0], w_cmp};
            end
            ddmix_pkg::OP_DIVDONE: begin
                if (i_cmd.sel) begin
                    r_rr <= w_divres;
                end else begin
                    r_lr <= w_divres;
                end
            end
            ddmix_pkg::OP_CODE: begin
                if (i_cmd.sel) begin
                    r_coder <= w_code[14:0];
                    r_revr  <= r_pol[1] ^ w_cur[16];
                end else begin
                    r_codel <= w_code[14:0];
                    r_revl  <= r_pol[0] ^ w_cur[16];
                end
            end
            ddmix_pkg::OP_OUTPUT: begin
                o_left_code     <= r_codel;
                o_left_reverse  <= r_revl;
                o_right_code    <= r_coder;
                o_right_reverse <= r_revr;
                o_left_command  <= r_prevl;
                o_right_command <= r_prevr;
            end
            default: r_p <= r_p;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/differential_drive_mixer.sv =====
// One request is taken at a time: the next is accepted only once the sequencer is back
// in idle. The shared multiplier steps 16 squarings and 16 exp2 factors per axis, and
// a 16-step divider runs per side when the mix is renormalized.
// A result waiting on the output holds the next request only in its finish step.
// Reset (synchronous, active low) restores register defaults and clears the
// stored commands.
// ============================================================================
// differential_drive_mixer: arcade mixer for a two-wheel differential drive
// Shapes the joystick axes, reduces turning with measured speed, mixes,
// renormalizes, smooths and maps the commands to DAC codes.
// ============================================================================
`default_nettype none

module differential_drive_mixer #(
    parameter int DAC_BITS = ddmix_pkg::DacBitsDefault
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ddmix_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [ddmix_pkg::CfgDataW-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [15:0]             i_stick_x,
    input  wire logic signed [15:0]             i_stick_y,
    input  wire logic signed [15:0]             i_speed_left,
    input  wire logic signed [15:0]             i_speed_right,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [14:0]                         o_left_code,
    output logic                                o_left_reverse,
    output logic [14:0]                         o_right_code,
    output logic                                o_right_reverse,
    output logic signed [16:0]                  o_left_command,
    output logic signed [16:0]                  o_right_command
);

    ddmix_pkg::t_cmd    w_cmd;
    ddmix_pkg::t_status w_status;

    // Sequencer.
    ddmix_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Datapath.
    ddmix_dp #(
        .DAC_BITS (DAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_stick_x       (i_stick_x),
        .i_stick_y       (i_stick_y),
        .i_speed_left    (i_speed_left),
        .i_speed_right   (i_speed_right),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_left_code     (o_left_code),
        .o_left_reverse  (o_left_reverse),
        .o_right_code    (o_right_code),
        .o_right_reverse (o_right_reverse),
        .o_left_command  (o_left_command),
        .o_right_command (o_right_command)
    );

endmodule

`default_nettype wire

// ===== tb/ddmix_command_checker.sv =====
// ============================================================================
// ddmix_command_checker: prediction and comparison for the drive mixer
// Watches the register port and both request channels. It keeps its own
// copy of the registers and of the smoothed commands, works out the codes,
// reverse levels and commands for every accepted request, and compares
// each accepted result with the oldest prediction.
// ============================================================================
`default_nettype none

module ddmix_command_checker
    import ddmix_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [CfgDataW-1:0]  i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic signed [15:0]   i_stick_x,
    input  wire logic signed [15:0]   i_stick_y,
    input  wire logic signed [15:0]   i_speed_left,
    input  wire logic signed [15:0]   i_speed_right,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [14:0]          i_left_code,
    input  wire logic                 i_left_reverse,
    input  wire logic [14:0]          i_right_code,
    input  wire logic                 i_right_reverse,
    input  wire logic signed [16:0]   i_left_command,
    input  wire logic signed [16:0]   i_right_command,
    output int                        o_mismatches,
    output int                        o_pending,
    output int                        o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [14:0]        left_code;
        logic               left_reverse;
        logic [14:0]        right_code;
        logic               right_reverse;
        logic signed [16:0] left_command;
        logic signed [16:0] right_command;
    } t_drive_out;

    t_drive_out drive_queue[$];

    // Shadow registers and stored commands.
    logic [14:0] dz_level;
    logic [9:0]  fwd_exp;
    logic [9:0]  turn_exp;
    logic [15:0] turn_red;
    logic [15:0] alpha_reg;
    logic [14:0] code_lo;
    logic [14:0] code_hi;
    logic [1:0]  polarity;
    int          last_left;
    int          last_right;

    // Q30 exp2 factors, entry b serves fraction bit b-1.
    longint unsigned exp2_factor[1:16];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = v;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    initial begin
        longint unsigned t;
        t = 64'd1 << 29;
        for (int b = 16; b >= 1; b--) begin
            t = int_sqrt(t << 30);
            exp2_factor[b] = t;
        end
    end

    // Magnitude 1..32768 raised to a Q2.8 exponent by log2 and exp2 steps.
    function automatic int power_curve(int m, logic [9:0] e);
        int              top;
        int unsigned     frac;
        longint unsigned x;
        longint unsigned n;
        longint unsigned q;
        longint unsigned r;
        int unsigned     ip;
        int unsigned     shift;
        top = 0;
        while (top < 15 && (m >> (top + 1)) != 0) top++;
        x = longint'(m) << (30 - top);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        n = (longint'(15 - top) << 16) - frac;
        q = (n * e) >> 8;
        ip = q >> 16;
        r = 64'd1 << 30;
        for (int b = 16; b >= 1; b--) begin
            if (q[b-1]) r = (r * exp2_factor[b]) >> 30;
        end
        shift = 15 + ip;
        if (shift > 40) return 0;
        return int'(r >> shift);
    endfunction

    function automatic int shape(logic signed [15:0] v, logic [9:0] e);
        int m;
        int c;
        m = (v < 0) ? -int'(v) : int'(v);
        if (m < dz_level || m == 0) return 0;
        c = power_curve(m, e);
        return (v < 0) ? -c : c;
    endfunction

    function automatic int smooth_step(int last, int target, int a);
        int     d;
        longint ad;
        int     stp;
        int     c;
        d   = target - last;
        ad  = (d < 0) ? -d : d;
        stp = int'((a * ad + 16384) >>> 15);
        c   = (d < 0) ? last - stp : last + stp;
        if (c > 32768) c = 32768;
        if (c < -32768) c = -32768;
        return c;
    endfunction

    function automatic logic [14:0] dac_code(int cmd);
        longint mag;
        longint prod;
        longint code;
        mag  = (cmd < 0) ? -cmd : cmd;
        prod = mag * (longint'(code_hi) - longint'(code_lo));
        code = code_lo + ((prod < 0) ? -((-prod) >>> 15) : (prod >>> 15));
        if (code > code_hi) code = code_hi;
        if (code > 32767) code = 32767;
        if (code < 0) code = 0;
        return code[14:0];
    endfunction

    // Shape, reduce turning, mix, renormalize, smooth and map one request.
    function automatic t_drive_out mix_drive(logic signed [15:0] sx, logic signed [15:0] sy,
                                             logic signed [15:0] sl, logic signed [15:0] sr);
        t_drive_out res;
        int     y;
        int     x;
        longint avg;
        longint p;
        longint fac;
        int     xe;
        int     lr;
        int     rr;
        longint la;
        longint ra;
        longint mx;
        int     a;
        y   = shape(sy, fwd_exp);
        x   = shape(sx, turn_exp);
        avg = ((sl < 0 ? -longint'(sl) : longint'(sl)) +
               (sr < 0 ? -longint'(sr) : longint'(sr))) >>> 1;
        p   = (longint'(turn_red) * avg) >>> 15;
        fac = (p > 32768) ? 0 : 32768 - p;
        xe  = int'(((x < 0 ? -longint'(x) : longint'(x)) * fac) >>> 15);
        if (x < 0) xe = -xe;
        lr = y + xe;
        rr = y - xe;
        la = (lr < 0) ? -lr : lr;
        ra = (rr < 0) ? -rr : rr;
        mx = (la > ra) ? la : ra;
        if (mx > 32768) begin
            lr = (lr < 0) ? -int'((la << 15) / mx) : int'((la << 15) / mx);
            rr = (rr < 0) ? -int'((ra << 15) / mx) : int'((ra << 15) / mx);
        end
        a = alpha_reg;
        if (a < 328) a = 328;
        if (a > 32768) a = 32768;
        last_left  = smooth_step(last_left, lr, a);
        last_right = smooth_step(last_right, rr, a);
        res.left_code     = dac_code(last_left);
        res.left_reverse  = polarity[0] ^ (last_left < 0);
        res.right_code    = dac_code(last_right);
        res.right_reverse = polarity[1] ^ (last_right < 0);
        res.left_command  = last_left[16:0];
        res.right_command = last_right[16:0];
        return res;
    endfunction

    // Register shadow, comparison of results, then prediction of requests.
    always @(posedge i_clk) begin
        t_drive_out want;
        t_drive_out got;
        if (!i_rst_n) begin
            dz_level   <= RstDeadzone;
            fwd_exp    <= RstFwdExp;
            turn_exp   <= RstTurnExp;
            turn_red   <= RstTurnRed;
            alpha_reg  <= RstAlpha;
            code_lo    <= RstMinCode;
            code_hi    <= RstMaxCode;
            polarity   <= RstPolarity;
            last_left  = 0;
            last_right = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEADZONE: dz_level  <= i_cfg_data[14:0];
                    CFG_FWD_EXP:  fwd_exp   <= i_cfg_data[9:0];
                    CFG_TURN_EXP: turn_exp  <= i_cfg_data[9:0];
                    CFG_TURN_RED: turn_red  <= i_cfg_data;
                    CFG_ALPHA:    alpha_reg <= i_cfg_data;
                    CFG_MIN_CODE: code_lo   <= i_cfg_data[14:0];
                    CFG_MAX_CODE: code_hi   <= i_cfg_data[14:0];
                    CFG_POLARITY: polarity  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_left_code, i_left_reverse, i_right_code, i_right_reverse,
                        i_left_command, i_right_command};
                o_results++;
                if (drive_queue.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = drive_queue.pop_front();
                    if (got !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                drive_queue.push_back(mix_drive(i_stick_x, i_stick_y, i_speed_left,
                                                i_speed_right));
        end
        o_pending = drive_queue.size();
    end

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_results    = 0;
    end

endmodule

`default_nettype wire

// ===== tb/differential_drive_mixer_tb.sv =====
// ============================================================================
// differential_drive_mixer_tb: stimulus and verdict for the drive mixer
// Drives directed and random joystick and speed requests through several
// register settings with random gaps and output stalls, and reports the
// outcome of the command checker.
// ============================================================================
`default_nettype none

module differential_drive_mixer_tb;
    import ddmix_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_stick_x = '0;
    logic signed [15:0] i_stick_y = '0;
    logic signed [15:0] i_speed_left = '0;
    logic signed [15:0] i_speed_right = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [14:0]        o_left_code;
    logic               o_left_reverse;
    logic [14:0]        o_right_code;
    logic               o_right_reverse;
    logic signed [16:0] o_left_command;
    logic signed [16:0] o_right_command;

    int mismatches;
    int pending;
    int results;
    int requests_sent = 0;
    int idle_cycles = 0;
    bit hold_req = 0;
    bit quiet = 0;
    logic [14:0] cur_deadzone = RstDeadzone;

    differential_drive_mixer dut (.*);

    ddmix_command_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall),
        .i_stick_x, .i_stick_y, .i_speed_left, .i_speed_right,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_left_code(o_left_code), .i_left_reverse(o_left_reverse),
        .i_right_code(o_right_code), .i_right_reverse(o_right_reverse),
        .i_left_command(o_left_command), .i_right_command(o_right_command),
        .o_mismatches(mismatches), .o_pending(pending), .o_results(results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    endfunction

    // Receiver: random stalls, quiet stretches, and one long hold on request.
    always begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat (gap_len()) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_DEADZONE) cur_deadzone = data[14:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(logic signed [15:0] sx, logic signed [15:0] sy,
                        logic signed [15:0] sl, logic signed [15:0] sr, bit no_gap);
        int gap;
        gap = (no_gap || quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stick_x     <= sx;
        i_stick_y     <= sy;
        i_speed_left  <= sl;
        i_speed_right <= sr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    // Drain: sender pauses until every prediction has been compared with a result.
    task automatic drain();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Stick value: extremes, values around the deadzone, small values around zero, or anything.
    function automatic logic signed [15:0] stick_val();
        int sel;
        int dz;
        sel = $urandom_range(0, 9);
        dz  = cur_deadzone;
        case (sel)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(($urandom_range(0, 1) ? 1 : -1) *
                          ($urandom_range(0, 2) + (dz > 1 ? dz - 1 : 1)));
            3: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] speed_val();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++)
            send(stick_val(), stick_val(), speed_val(), speed_val(), 1'b0);
    endtask

    task automatic write_all(logic [15:0] dz, logic [15:0] fe, logic [15:0] te,
                             logic [15:0] tr, logic [15:0] al, logic [15:0] lo,
                             logic [15:0] hi, logic [15:0] pol);
        cfg_write(CFG_DEADZONE, dz);
        cfg_write(CFG_FWD_EXP, fe);
        cfg_write(CFG_TURN_EXP, te);
        cfg_write(CFG_TURN_RED, tr);
        cfg_write(CFG_ALPHA, al);
        cfg_write(CFG_MIN_CODE, lo);
        cfg_write(CFG_MAX_CODE, hi);
        cfg_write(CFG_POLARITY, pol);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed requests with reset register values.
        send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send(16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0);
        send(16'sd0, 16'sh8000, 16'sd0, 16'sd0, 1'b0);
        send(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send(16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send(16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0);
        send(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0);
        send(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 1'b0);
        send(16'sd1637, 16'sd1638, 16'sd0, 16'sd0, 1'b0);
        send(-16'sd1638, -16'sd1637, 16'sd0, 16'sd0, 1'b0);
        send(16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send(16'sh8000, 16'sd0, 16'sh8000, 16'sh8000, 1'b0);
        send(16'sh7FFF, 16'sd0, 16'sd16384, -16'sd16384, 1'b0);
        send(16'sd1, -16'sd1, 16'sh8000, 16'sh7FFF, 1'b0);
        send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        drain();

        // Exponent zero, full smoothing, no turn reduction, swapped codes.
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd30000, 16'd100, 16'd3);
        send(16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0);
        send(16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 1'b0);
        send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        random_burst(60);
        drain();

        // Steepest curves, slowest smoothing, strongest turn reduction.
        write_all(16'h7FFF, 16'd1023, 16'd1023, 16'hFFFF, 16'd0, 16'd0, 16'h7FFF, 16'd1);
        send(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0);
        random_burst(40);
        drain();

        // Gentle curves, fast smoothing, long receiver hold to fill the block.
        write_all(16'd100, 16'd256, 16'd256, 16'd32768, 16'hFFFF, 16'd0, 16'd0, 16'd2);
        hold_req = 1;
        random_burst(70);
        drain();

        // Random register values (deadzone up to 4000), one phase with no idling at all.
        for (int ph = 0; ph < 4; ph++) begin
            write_all(16'($urandom_range(0, 4000)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
            quiet = (ph == 1);
            random_burst(55);
            drain();
        end
        quiet = 0;

        $display("%0d requests and %0d results checked over eight register settings",
                 requests_sent, results);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
